// ===== hw/rtl/ber_tlv_header_walker_core_macros.svh =====
// ----------------------------------------------------------------------------
// BER TLV header walker assertion macros
// Concurrent checks for the header walker, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_HEADER_WALKER_CORE_MACROS_SVH
`define BER_TLV_HEADER_WALKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BTLV_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btlv check failed");
// next-cycle implication
`define BTLV_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btlv check failed");
`else
`define BTLV_ASSERT_NOW(name, clk, rst, ante, cons)
`define BTLV_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// BER TLV header walker package
// Payload types and fixed constants shared by the walker modules.
// ----------------------------------------------------------------------------
package btlv_pkg;

   localparam int ACC_W       = 40;
   localparam int LEN_W       = 24;
   localparam int OUT_OFF_W   = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_ERROR  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_OCTETS    = 3'd1;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
   localparam logic [2:0] ERR_EARLY_END = 3'd3;
   localparam logic [2:0] ERR_INDEF     = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_OCTETS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_INDEF = 2'd2;

   localparam logic [7:0]       LEN_INDEF       = 8'h80;
   localparam logic [6:0]       LEN_COUNT_MASK  = 7'h7F;
   localparam logic [2:0]       MAX_LONG_OCTETS = 3'd5;
   localparam logic [LEN_W-1:0] LEN_LIMIT       = 24'hFFFFFF;
   localparam int               TAG_CONS_BIT    = 5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           tag_byte;
      logic [LEN_W-1:0]     content_length;
      logic                 indefinite;
      logic [OUT_OFF_W-1:0] header_offset;
      logic [OUT_OFF_W-1:0] body_offset;
      logic [2:0]           error_code;
      logic                 last_result;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first_rsp;
      rsp_type    second_rsp;
   } push_type;

endpackage

// ===== hw/rtl/ber_tlv_header_walker_core.sv =====
// ----------------------------------------------------------------------------
// BER TLV header walker core
// Walks a BER byte stream, reporting each tag/length header with offsets,
// plus errors and the clean end of each encoding.
//
//   channel | ports         | direction | payload
//   --------+---------------+-----------+--------------------------------
//   request | req_*         | in        | one encoding byte + first/last
//   result  | rsp_*         | out       | header, error or end record
//   config  | csr_*         | in        | register index + write data
//
// One byte is taken per cycle while req_ready is high; the result appears in
// the queue the next cycle. Two results (header plus end) hold two slots, so
// the queue sets the rate: one result leaves per cycle when rsp_ready is high.
// Reset is synchronous; configuration registers come back to their defaults.
// A stalled result side drops req_ready once fewer than two of the 4 queue
// slots are free.
// ----------------------------------------------------------------------------
`include "ber_tlv_header_walker_core_macros.svh"

module ber_tlv_header_walker_core #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  btlv_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output btlv_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [btlv_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [btlv_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import btlv_pkg::*;

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_LONG,
      PH_SKIP
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            tag_ff, tag_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [2:0]            octets_ff, octets_in;
   logic [LEN_W-1:0]      skip_ff, skip_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in;
   logic [OFFSET_WIDTH-1:0] tagpos_ff, tagpos_in;
   logic                  halted_ff, halted_in;

   logic [2:0]            max_octets_ff;
   logic [LEN_W-1:0]      max_length_ff;
   logic                  allow_indef_ff;

   logic                  req_fire;
   logic                  space_ok;
   push_type              push;

   logic [OFFSET_WIDTH-1:0] pos;
   logic [OUT_OFF_W-1:0]  boff;
   logic [7:0]            b;
   logic [2:0]            lim;
   logic                  def_v;
   logic [ACC_W-1:0]      def_len;
   logic                  prim_v;
   rsp_type               prim;
   logic                  end_v;
   rsp_type               endr;

   assign req_ready = space_ok;
   assign req_fire  = req_valid & req_ready;
   assign b         = req_data.data_byte;
   assign lim       = (max_octets_ff > MAX_LONG_OCTETS) ? MAX_LONG_OCTETS : max_octets_ff;

   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      acc_in    = acc_ff;
      octets_in = octets_ff;
      skip_in   = skip_ff;
      off_in    = off_ff;
      tagpos_in = tagpos_ff;
      halted_in = halted_ff;
      pos       = off_ff;
      boff      = '0;
      def_v     = 1'b0;
      def_len   = '0;
      prim_v    = 1'b0;
      prim      = '0;
      end_v     = 1'b0;
      endr      = '0;
      if (req_fire) begin
         if (req_data.first_byte) begin
            off_in    = '0;
            halted_in = 1'b0;
            phase_in  = PH_TAG;
            octets_in = '0;
            skip_in   = '0;
            acc_in    = '0;
         end
         if (!halted_in) begin
            pos    = off_in;
            off_in = pos + OFFSET_WIDTH'(1);
            boff   = OUT_OFF_W'(off_in);
            case (phase_in)
               PH_TAG: begin
                  tag_in    = b;
                  tagpos_in = pos;
                  phase_in  = PH_LEN;
               end
               PH_LEN: begin
                  if (b == LEN_INDEF) begin
                     prim_v = 1'b1;
                     if (!tag_in[TAG_CONS_BIT] || !allow_indef_ff) begin
                        prim      = '{KIND_ERROR, tag_in, '0, 1'b0,
                                      OUT_OFF_W'(tagpos_in), boff, ERR_INDEF, 1'b0};
                        halted_in = 1'b1;
                     end else begin
                        prim = '{KIND_HEADER, tag_in, '0, 1'b1,
                                 OUT_OFF_W'(tagpos_in), boff, ERR_NONE, 1'b0};
                     end
                     phase_in = PH_TAG;
                  end else if (b[7]) begin
                     if ((b[6:0] & LEN_COUNT_MASK) > {4'd0, lim}) begin
                        prim_v    = 1'b1;
                        prim      = '{KIND_ERROR, tag_in, '0, 1'b0,
                                      OUT_OFF_W'(tagpos_in), boff, ERR_OCTETS, 1'b0};
                        halted_in = 1'b1;
                        phase_in  = PH_TAG;
                     end else begin
                        acc_in    = '0;
                        octets_in = b[2:0];
                        phase_in  = PH_LONG;
                     end
                  end else begin
                     def_v   = 1'b1;
                     def_len = ACC_W'(b);
                  end
               end
               PH_LONG: begin
                  acc_in = {acc_in[ACC_W-9:0], b};
                  if (octets_in != 3'd0) begin
                     octets_in = octets_in - 3'd1;
                  end
                  if (octets_in == 3'd0) begin
                     def_v   = 1'b1;
                     def_len = acc_in;
                  end
               end
               PH_SKIP: begin
                  if (skip_in != '0) begin
                     skip_in = skip_in - LEN_W'(1);
                  end
                  if (skip_in == '0) begin
                     phase_in = PH_TAG;
                  end
               end
               default: begin
                  phase_in = PH_TAG;
               end
            endcase
            if (def_v) begin
               prim_v = 1'b1;
               if ((def_len[ACC_W-1:LEN_W] != '0) || (def_len[LEN_W-1:0] > max_length_ff)) begin
                  prim      = '{KIND_ERROR, tag_in, '0, 1'b0,
                                OUT_OFF_W'(tagpos_in), boff, ERR_TOO_LARGE, 1'b0};
                  halted_in = 1'b1;
                  phase_in  = PH_TAG;
               end else begin
                  prim = '{KIND_HEADER, tag_in, def_len[LEN_W-1:0], 1'b0,
                           OUT_OFF_W'(tagpos_in), boff, ERR_NONE, 1'b0};
                  if (!tag_in[TAG_CONS_BIT] && (def_len != '0)) begin
                     skip_in  = def_len[LEN_W-1:0];
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_TAG;
                  end
               end
            end
            if (!halted_in && req_data.last_byte) begin
               end_v = 1'b1;
               if (phase_in == PH_TAG) begin
                  endr = '{KIND_END, 8'd0, '0, 1'b0, boff, boff, ERR_NONE, 1'b1};
               end else begin
                  endr = '{KIND_ERROR, tag_in, '0, 1'b0,
                           OUT_OFF_W'(tagpos_in), boff, ERR_EARLY_END, 1'b1};
               end
               halted_in = 1'b1;
               phase_in  = PH_TAG;
            end
         end
      end
      prim.last_result = !end_v;
      push.count       = {1'b0, prim_v} + {1'b0, end_v};
      push.first_rsp   = prim_v ? prim : endr;
      push.second_rsp  = endr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TAG;
         tag_ff         <= '0;
         acc_ff         <= '0;
         octets_ff      <= '0;
         skip_ff        <= '0;
         off_ff         <= '0;
         tagpos_ff      <= '0;
         halted_ff      <= 1'b0;
         max_octets_ff  <= MAX_LONG_OCTETS;
         max_length_ff  <= LEN_LIMIT;
         allow_indef_ff <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         acc_ff    <= acc_in;
         octets_ff <= octets_in;
         skip_ff   <= skip_in;
         off_ff    <= off_in;
         tagpos_ff <= tagpos_in;
         halted_ff <= halted_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_OCTETS:  max_octets_ff  <= csr_wdata[2:0];
               CSR_MAX_LENGTH:  max_length_ff  <= csr_wdata[LEN_W-1:0];
               CSR_ALLOW_INDEF: allow_indef_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   btlv_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `BTLV_ASSERT_NOW(a_push_needs_transfer, clock, reset,
      push.count != 2'd0, req_fire)
   `BTLV_ASSERT_NOW(a_halted_silent, clock, reset,
      req_fire && halted_ff && !req_data.first_byte, push.count == 2'd0)
   `BTLV_ASSERT_NEXT(a_last_halts, clock, reset,
      req_fire && req_data.last_byte && (req_data.first_byte || !halted_ff),
      halted_ff && (phase_ff == PH_TAG))
   `BTLV_ASSERT_NOW(a_skip_nonzero, clock, reset,
      phase_ff == PH_SKIP, skip_ff != '0)

endmodule

// ===== hw/rtl/btlv_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// BER TLV result queue
// Small result FIFO taking up to two results per cycle, one out per transfer.
// ----------------------------------------------------------------------------
module btlv_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  btlv_pkg::push_type push,
   output logic              space_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output btlv_pkg::rsp_type rsp_data
);
   import btlv_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;
   assign space_ok  = (count_ff <= CNT_W'(QUEUE_DEPTH - 2)) |
                      ((count_ff == CNT_W'(QUEUE_DEPTH - 1)) & pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first_rsp;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.second_rsp;
      end
   end

endmodule
